// ===== src/bca_pkg.sv =====
// Shared types, codes and helpers for the bitmap cluster allocator.
// Depends on nothing; the top level and bca_summary import it.
package bca_pkg;

  localparam int CLUSTER_W = 12;
  localparam int CFG_W     = 13;
  localparam int WORD_W    = 32;

  localparam logic [CFG_W-1:0]  DISK_CLUSTERS_RST = 13'd4096;
  localparam logic [WORD_W-1:0] ALL_FREE          = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ACT_ACQUIRE = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_TAKE    = 2'd2,
    ACT_QUERY   = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    status_e                status;
    logic                   is_free;
    logic [CLUSTER_W-1:0]   cluster;
  } res_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [4:0] lsb32(input logic [WORD_W-1:0] v);
    logic [4:0] idx;
    idx = 5'd0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = 5'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== src/bitmap_cluster_allocator.sv =====
// Top level of the bitmap cluster allocator: request sequencer, APB register,
// output register. Uses bca_pkg, bca_map_ram and bca_summary.
//
// The block handles one request at a time. From the input transfer to the result
// standing on the output, acquire passes through group search, word search with the
// map read, modify and write back, and output load; release, mark-taken and query
// pass through modify and write back and output load, and a request with an
// out-of-range cluster goes straight to output load. The map RAM's registered read
// lies inside the read-modify-write sequence. A new request is taken only once the
// last one has been loaded onto the output and the block is back in idle. A new
// request is taken while a finished result still waits on the output. After reset a
// clearing pass writes every map word free, one word per cycle; requests are held
// off during it, register writes are taken as usual. disk_clusters lies at byte
// address 0.
module bitmap_cluster_allocator
  import bca_pkg::*;
#(
  parameter int MAX_CLUSTER_COUNT = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // cluster_in[11:0], zero pad[15:12]
  input  logic [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // cluster_out[11:0], is_free[12], status[14:13], pad[15]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int MAP_WORDS = (MAX_CLUSTER_COUNT + 31) / 32;
  localparam int GROUPS    = (MAP_WORDS + 31) / 32;
  localparam int GW        = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int WFW       = GW + 5;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int SZB       = $clog2(MAX_CLUSTER_COUNT + 1);
  localparam int SZW       = (SZB > CFG_W) ? SZB : CFG_W;
  localparam logic [SZW-1:0] MAX_SIZE = SZW'(MAX_CLUSTER_COUNT);
  localparam logic [AW-1:0]  LAST_WORD = AW'(MAP_WORDS - 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_GRP   = 6'b000100,
    S_WSEL  = 6'b001000,
    S_RMW   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CFG_W-1:0]     dc_r;
  logic [AW-1:0]        clr_r, clr_nxt;
  act_e                 act_r, act_nxt;
  logic [CLUSTER_W-1:0] cl_r, cl_nxt;
  logic [WFW-1:0]       word_r, word_nxt;
  logic [4:0]           bit_r, bit_nxt;
  logic [GW-1:0]        grp_r, grp_nxt;
  res_t                 res_r, res_nxt;
  res_t                 out_r;
  logic                 out_valid_r;

  logic [SZW-1:0]       dc_ext;
  logic [SZW-1:0]       eff;
  logic [SZW:0]         eff_up;
  logic [WFW:0]         wlimit;

  logic                 in_acc;
  act_e                 in_act;
  logic [CLUSTER_W-1:0] in_cl;
  logic [WFW+6:0]       in_word_x;

  logic                 grp_found, word_found;
  logic [GW-1:0]        grp_idx;
  logic [WFW-1:0]       word_idx;

  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [31:0]          rd_data;
  logic                 map_we;
  logic [AW-1:0]        map_wa;
  logic [31:0]          map_wd;
  logic                 upd_en;

  logic [SZW-1:0]       n_avail;
  logic [31:0]          rev_bits;
  logic [31:0]          usable;
  logic [4:0]           grant_off;
  logic [WFW+4:0]       grant;
  logic [WFW+16:0]      grant_x;
  logic [31:0]          bit_mask;
  logic                 out_free;

  assign dc_ext = SZW'(dc_r);
  assign eff    = (dc_ext > MAX_SIZE) ? MAX_SIZE : dc_ext;
  assign eff_up = {1'b0, eff} + (SZW + 1)'(31);
  assign wlimit = eff_up[WFW+5:5];

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {{(32 - CFG_W){1'b0}}, dc_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_r <= DISK_CLUSTERS_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2]) begin
      dc_r <= cfg_pwdata[CFG_W-1:0];
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_act    = act_e'(in_tuser);
  assign in_cl     = in_tdata[CLUSTER_W-1:0];
  assign in_word_x = {{WFW{1'b0}}, in_cl[11:5]};
  assign out_free  = !out_valid_r || out_tready;

  bca_summary #(
    .MAP_WORDS (MAP_WORDS),
    .GROUPS    (GROUPS),
    .GW        (GW),
    .WFW       (WFW)
  ) u_summary (
    .clk         (clk),
    .rst_n       (rst_n),
    .upd_en      (upd_en),
    .upd_word    (word_r),
    .upd_nonzero (map_wd != 32'd0),
    .sel_grp     (grp_r),
    .wlimit      (wlimit),
    .grp_found   (grp_found),
    .grp_idx     (grp_idx),
    .word_found  (word_found),
    .word_idx    (word_idx)
  );

  bca_map_ram #(
    .DEPTH (MAP_WORDS),
    .AW    (AW)
  ) u_map (
    .clk (clk),
    .we  (map_we),
    .wa  (map_wa),
    .wd  (map_wd),
    .re  (rd_en),
    .ra  (rd_addr),
    .rd  (rd_data)
  );

  always_comb begin
    n_avail = eff - SZW'({word_r, 5'b0});
    for (int o = 0; o < 32; o++) begin
      rev_bits[o] = rd_data[31 - o];
      usable[o]   = rev_bits[o] && (SZW'(o) < n_avail);
    end
    grant_off = lsb32(usable);
    grant     = {word_r, grant_off};
    grant_x   = {12'd0, grant};
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    act_nxt   = act_r;
    cl_nxt    = cl_r;
    word_nxt  = word_r;
    bit_nxt   = bit_r;
    grp_nxt   = grp_r;
    res_nxt   = res_r;
    rd_en     = 1'b0;
    rd_addr   = word_r[AW-1:0];
    map_we    = 1'b0;
    map_wa    = word_r[AW-1:0];
    map_wd    = rd_data;
    upd_en    = 1'b0;
    bit_mask  = 32'd1 << (~bit_r);
    case (state_r)
      S_CLEAR: begin
        map_we  = 1'b1;
        map_wa  = clr_r;
        map_wd  = ALL_FREE;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == LAST_WORD) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          act_nxt  = in_act;
          cl_nxt   = in_cl;
          word_nxt = in_word_x[WFW-1:0];
          bit_nxt  = in_cl[4:0];
          if (in_act == ACT_ACQUIRE) begin
            state_nxt = S_GRP;
          end else if (SZW'(in_cl) >= eff) begin
            res_nxt   = '{status: ST_RANGE, is_free: 1'b0, cluster: in_cl};
            state_nxt = S_DONE;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = in_word_x[AW-1:0];
            state_nxt = S_RMW;
          end
        end
      end
      S_GRP: begin
        if (grp_found) begin
          grp_nxt   = grp_idx;
          state_nxt = S_WSEL;
        end else begin
          res_nxt   = '{status: ST_FULL, is_free: 1'b0, cluster: '0};
          state_nxt = S_DONE;
        end
      end
      S_WSEL: begin
        if (word_found) begin
          word_nxt  = word_idx;
          rd_en     = 1'b1;
          rd_addr   = word_idx[AW-1:0];
          state_nxt = S_RMW;
        end else begin
          res_nxt   = '{status: ST_FULL, is_free: 1'b0, cluster: '0};
          state_nxt = S_DONE;
        end
      end
      S_RMW: begin
        state_nxt = S_DONE;
        case (act_r)
          ACT_ACQUIRE: begin
            if (|usable) begin
              map_we  = 1'b1;
              upd_en  = 1'b1;
              map_wd  = rd_data & ~(32'd1 << (~grant_off));
              res_nxt = '{status: ST_OK, is_free: 1'b0, cluster: grant_x[CLUSTER_W-1:0]};
            end else begin
              res_nxt = '{status: ST_FULL, is_free: 1'b0, cluster: '0};
            end
          end
          ACT_RELEASE: begin
            map_we  = 1'b1;
            upd_en  = 1'b1;
            map_wd  = rd_data | bit_mask;
            res_nxt = '{status: ST_OK, is_free: 1'b0, cluster: cl_r};
          end
          ACT_TAKE: begin
            map_we  = 1'b1;
            upd_en  = 1'b1;
            map_wd  = rd_data & ~bit_mask;
            res_nxt = '{status: ST_OK, is_free: 1'b0, cluster: cl_r};
          end
          ACT_QUERY: begin
            res_nxt = '{status: ST_OK, is_free: rd_data[~bit_r], cluster: cl_r};
          end
          default: begin
            res_nxt = '{status: ST_OK, is_free: 1'b0, cluster: cl_r};
          end
        endcase
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r  <= act_nxt;
    cl_r   <= cl_nxt;
    word_r <= word_nxt;
    bit_r  <= bit_nxt;
    grp_r  <= grp_nxt;
    res_r  <= res_nxt;
    if (state_r == S_DONE && out_free) begin
      out_r <= res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_r};

`ifndef ASSERT_OFF
  a_rmw_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RMW |-> $past(rd_en))
    else $error("read-modify-write step without a map read in the cycle before");

  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    map_we && state_r != S_CLEAR |-> state_r == S_RMW && act_r != ACT_QUERY)
    else $error("map written outside a modifying request");

  a_grant_in_size: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RMW && act_r == ACT_ACQUIRE && map_we |-> SZW'(grant) < eff)
    else $error("acquire granted a cluster at or beyond the disk size");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |=> !$past(in_acc) && !out_valid_r)
    else $error("request transfer or result during the clearing pass");
`endif

endmodule

// ===== src/bca_map_ram.sv =====
// Free map storage: single write port, single read port, registered read data.
// Uses no package items; instantiated by the top level.
module bca_map_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [31:0]   wd,
  input  logic          re,
  input  logic [AW-1:0] ra,
  output logic [31:0]   rd
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

// ===== src/bca_summary.sv =====
// Per-word nonzero summary and per-group summary with the two-level search
// that acquire uses to pick a word. Imports bca_pkg for lsb32.
module bca_summary
  import bca_pkg::*;
#(
  parameter int MAP_WORDS = 128,
  parameter int GROUPS    = 4,
  parameter int GW        = 2,
  parameter int WFW       = 7
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           upd_en,
  input  logic [WFW-1:0] upd_word,
  input  logic           upd_nonzero,
  input  logic [GW-1:0]  sel_grp,
  input  logic [WFW:0]   wlimit,
  output logic           grp_found,
  output logic [GW-1:0]  grp_idx,
  output logic           word_found,
  output logic [WFW-1:0] word_idx
);

  localparam int NS = GROUPS * 32;

  logic [NS-1:0]     summ_r;
  logic [GROUPS-1:0] group_r;
  logic [31:0]       upd_chunk;
  logic [31:0]       sel_chunk;
  logic [31:0]       sel_mask;
  logic [31:0]       sel_hits;

  always_comb begin
    upd_chunk = summ_r[{upd_word[WFW-1:5], 5'b0} +: 32];
    upd_chunk[upd_word[4:0]] = upd_nonzero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) begin
        summ_r[i] <= (i < MAP_WORDS);
      end
      group_r <= '1;
    end else if (upd_en) begin
      summ_r[upd_word] <= upd_nonzero;
      group_r[upd_word[WFW-1:5]] <= |upd_chunk;
    end
  end

  always_comb begin
    grp_found = |group_r;
    grp_idx   = '0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (group_r[g]) begin
        grp_idx = GW'(g);
      end
    end
  end

  always_comb begin
    sel_chunk = summ_r[{sel_grp, 5'b0} +: 32];
    for (int i = 0; i < 32; i++) begin
      sel_mask[i] = ({1'b0, sel_grp, 5'(i)} < wlimit);
    end
    sel_hits   = sel_chunk & sel_mask;
    word_found = |sel_hits;
    word_idx   = {sel_grp, lsb32(sel_hits)};
  end

endmodule
